### design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BIDX_W   = 16;
    localparam int WIDX_W   = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_MARK  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT = 1'b1;

    localparam logic [BIDX_W-1:0] TOTAL_RESET = 16'd4096;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [BIDX_W-1:0] block_index;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [BIDX_W-1:0] allocated_block;
        logic              bit_used;
        logic [BIDX_W-1:0] free_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SWEEP,
        ST_SCAN,
        ST_RMW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic init_start;
        logic sweep_step;
        logic scan_start;
        logic scan_step;
        logic rmw_read;
        logic rmw_write;
        logic set_fail;
        logic set_used_oor;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       in_range;
        logic       alloc_empty;
        logic       sweep_last;
        logic       scan_hit;
        logic       scan_end;
    } t_sts;

endpackage

### design/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit block allocator over a one-bit-per-block used map.
// ----------------------------------------------------------------------------
// Items enter on i_in_valid / o_in_ready and carry an opcode and a block
// index; each item gives exactly one result item on o_out_valid /
// i_out_ready. Configuration writes use i_cfg_valid / o_cfg_ready with an
// index (0 first data block, 1 total block count) and 16-bit data; they are
// taken at once and belong only to idle periods.
// The map lives in a single-port-write memory of W = MAP_BLOCKS*BLOCK_BYTES/8
// words of 64 bits, and every operation is bounded by that memory's port:
//   free, mark, query : in range a read, then a modify/write; out of range
//                       no map access
//   allocate          : a word scan, one word per cycle with find-first-zero
//                       (W words at most); no scan when no block lies in the
//                       allocatable range
//   init              : all W words written, one word per cycle
//   others            : no map access
// One item is in flight at a time; a new item is taken as soon as the
// previous one has left the datapath.
// After reset the block clears every map word with o_in_ready low.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and held finished until that register frees.
// ----------------------------------------------------------------------------
module block_bitmap_allocator #(
    parameter int MAP_BLOCKS  = 1,
    parameter int BLOCK_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bba_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bba_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bba_pkg::BIDX_W-1:0]    i_cfg_data
);

    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bba_dp #(
        .MAP_BLOCKS  (MAP_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_item  (o_out_item)
    );

endmodule

### design/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: map clearing after reset, operation dispatch,
// word scan and read-modify-write, and the output item register valid.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output bba_pkg::t_cmd o_cmd,
    input  bba_pkg::t_sts i_sts
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;
    logic            r_out_valid;
    logic            out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == bba_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            bba_pkg::ST_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = bba_pkg::ST_DISPATCH;
                end
            end
            bba_pkg::ST_DISPATCH: begin
                case (i_sts.op)
                    bba_pkg::OP_INIT: begin
                        o_cmd.init_start = 1'b1;
                        n_state          = bba_pkg::ST_SWEEP;
                    end
                    bba_pkg::OP_ALLOC: begin
                        if (i_sts.alloc_empty) begin
                            o_cmd.set_fail = 1'b1;
                            n_state        = bba_pkg::ST_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = bba_pkg::ST_SCAN;
                        end
                    end
                    bba_pkg::OP_FREE, bba_pkg::OP_MARK, bba_pkg::OP_QUERY: begin
                        if (i_sts.in_range) begin
                            o_cmd.rmw_read = 1'b1;
                            n_state        = bba_pkg::ST_RMW;
                        end else begin
                            o_cmd.set_used_oor = (i_sts.op == bba_pkg::OP_QUERY);
                            n_state            = bba_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        n_state = bba_pkg::ST_DONE;
                    end
                endcase
            end
            bba_pkg::ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = bba_pkg::ST_DONE;
                end else if (i_sts.scan_end) begin
                    o_cmd.set_fail = 1'b1;
                    n_state        = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_RMW: begin
                o_cmd.rmw_write = 1'b1;
                n_state         = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_IDLE;
            end
        endcase
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while full");

    a_hit_end_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::ST_SCAN) |-> !(i_sts.scan_hit && i_sts.scan_end))
        else $error("scan reports hit and end together");

    a_dispatch_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::ST_DISPATCH) |=> (r_state != bba_pkg::ST_IDLE))
        else $error("item dropped without a result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result lost under stall");

endmodule

### design/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: configuration registers, used map memory, free count, the shared
// sweep/scan word counter, find-first-zero on one map word, result registers.
// ----------------------------------------------------------------------------
module bba_dp #(
    parameter int MAP_BLOCKS  = 1,
    parameter int BLOCK_BYTES = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bba_pkg::t_in_item                 i_in_item,
    input  logic                              i_cfg_valid,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bba_pkg::BIDX_W-1:0]        i_cfg_data,
    input  bba_pkg::t_cmd                     i_cmd,
    output bba_pkg::t_sts                     o_sts,
    output bba_pkg::t_out_item                o_out_item
);

    localparam int CAP_BITS  = MAP_BLOCKS * BLOCK_BYTES * 8;
    localparam int MAP_WORDS = (CAP_BITS + 63) / 64;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW        = (AW > bba_pkg::WIDX_W) ? AW : bba_pkg::WIDX_W;
    localparam logic [16:0] CAP_SAT = (CAP_BITS > 65536) ? 17'h10000 : 17'(CAP_BITS);
    localparam logic [CW-1:0] LAST_WORD = CW'(MAP_WORDS - 1);

    logic [63:0] r_map [MAP_WORDS];

    logic [15:0]   r_fdb;
    logic [15:0]   r_total;
    logic [2:0]    r_op;
    logic [15:0]   r_idx;
    logic [15:0]   r_free;
    logic [15:0]   r_ilim;
    logic [CW-1:0] r_wcnt;
    logic [CW-1:0] r_rdw;
    logic          r_rd_vld;
    logic [63:0]   r_rdata;
    logic          r_status;
    logic [15:0]   r_alloc;
    logic          r_used;
    bba_pkg::t_out_item r_out;

    logic [15:0]   scan_lim;
    logic [15:0]   limm1;
    logic [CW-1:0] last_w;
    logic [CW-1:0] fdb_w;
    logic [CW-1:0] idx_w;
    logic [CW-1:0] ilim_w;
    logic [63:0]   lo_mask;
    logic [63:0]   hi_mask;
    logic [63:0]   free_bits;
    logic [5:0]    hit_pos;
    logic          hit;
    logic [63:0]   sweep_word;
    logic [63:0]   idx_bit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    assign scan_lim = ({1'b0, r_total} < CAP_SAT) ? r_total : CAP_SAT[15:0];
    assign limm1    = scan_lim - 16'd1;
    assign last_w   = CW'(limm1[15:6]);
    assign fdb_w    = CW'(r_fdb[15:6]);
    assign idx_w    = CW'(r_idx[15:6]);
    assign ilim_w   = CW'(r_ilim[15:6]);
    assign idx_bit  = 64'd1 << r_idx[5:0];

    assign lo_mask   = (r_rdw == fdb_w) ? ~((64'd1 << r_fdb[5:0]) - 64'd1) : '1;
    assign hi_mask   = (r_rdw == last_w) ? ({64{1'b1}} >> (6'd63 - limm1[5:0])) : '1;
    assign free_bits = ~r_rdata & lo_mask & hi_mask;
    assign hit       = r_rd_vld && (|free_bits);

    always_comb begin
        hit_pos = '0;
        for (int i = 63; i >= 0; i--) begin
            if (free_bits[i]) begin
                hit_pos = 6'(i);
            end
        end
    end

    always_comb begin
        if (r_wcnt < ilim_w) begin
            sweep_word = '1;
        end else if (r_wcnt == ilim_w) begin
            sweep_word = (64'd1 << r_ilim[5:0]) - 64'd1;
        end else begin
            sweep_word = '0;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rdw[AW-1:0];
        mem_wdata = r_rdata;
        if (i_cmd.sweep_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_wcnt[AW-1:0];
            mem_wdata = sweep_word;
        end else if (i_cmd.scan_step && hit) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata | (64'd1 << hit_pos);
        end else if (i_cmd.rmw_write && (r_op == bba_pkg::OP_FREE)) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata & ~idx_bit;
        end else if (i_cmd.rmw_write && (r_op == bba_pkg::OP_MARK)) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata | idx_bit;
        end
    end

    assign mem_re    = i_cmd.rmw_read || (i_cmd.scan_step && (r_wcnt <= last_w));
    assign mem_raddr = i_cmd.rmw_read ? idx_w[AW-1:0] : r_wcnt[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_map[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdb    <= '0;
            r_total  <= bba_pkg::TOTAL_RESET;
            r_free   <= '0;
            r_ilim   <= '0;
            r_wcnt   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bba_pkg::CFG_FIRST_DATA:  r_fdb   <= i_cfg_data;
                    bba_pkg::CFG_TOTAL_COUNT: r_total <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.init_start) begin
                r_wcnt <= '0;
                r_ilim <= ({1'b0, r_fdb} < CAP_SAT) ? r_fdb : CAP_SAT[15:0];
                r_free <= (r_total > r_fdb) ? (r_total - r_fdb) : '0;
            end
            if (i_cmd.sweep_step) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_wcnt   <= fdb_w;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_wcnt   <= r_wcnt + 1'b1;
                r_rdw    <= r_wcnt;
                r_rd_vld <= 1'b1;
                if (hit && (r_free != '0)) begin
                    r_free <= r_free - 16'd1;
                end
            end
            if (i_cmd.rmw_read) begin
                r_rdw <= idx_w;
            end
            if (i_cmd.rmw_write && (r_op == bba_pkg::OP_FREE) && (r_free != 16'hFFFF)) begin
                r_free <= r_free + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_in_item.opcode;
            r_idx    <= i_in_item.block_index;
            r_status <= 1'b0;
            r_alloc  <= '0;
            r_used   <= 1'b0;
        end
        if (i_cmd.set_fail) begin
            r_status <= 1'b1;
        end
        if (i_cmd.set_used_oor) begin
            r_used <= 1'b1;
        end
        if (i_cmd.scan_step && hit) begin
            r_alloc <= {r_rdw[bba_pkg::WIDX_W-1:0], hit_pos};
        end
        if (i_cmd.rmw_write && (r_op == bba_pkg::OP_QUERY)) begin
            r_used <= r_rdata[r_idx[5:0]];
        end
        if (i_cmd.out_load) begin
            r_out.status          <= r_status;
            r_out.allocated_block <= r_alloc;
            r_out.bit_used        <= r_used;
            r_out.free_count      <= r_free;
        end
    end

    assign o_out_item = r_out;

    assign o_sts.op          = r_op;
    assign o_sts.in_range    = (r_idx < r_total) && ({1'b0, r_idx} < CAP_SAT);
    assign o_sts.alloc_empty = (r_fdb >= scan_lim);
    assign o_sts.sweep_last  = (r_wcnt == LAST_WORD);
    assign o_sts.scan_hit    = hit;
    assign o_sts.scan_end    = r_rd_vld && !hit && (r_rdw == last_w);

endmodule
